>>> design/irt_pkg.sv
// Shared types for the interval range table: cell commands and cell compare flags.
package irt_pkg;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,   // keep contents
        CELL_PULL,   // cells at or above pos take the right neighbor (delete at pos)
        CELL_PUSH    // cell at pos loads insert data, cells above take the left neighbor
    } cell_op_t;

    // Compare results of one cell against the probe keys.
    typedef struct packed {
        logic lt_begin;   // key <  key_begin
        logic le_begin;   // key <= key_begin
        logic lt_end;     // key <  key_end
        logic eq_end;     // key == key_end
    } cell_flags_t;

endpackage

>>> design/irt_cell.sv
// One boundary cell of the interval range table chain.
module irt_cell
    import irt_pkg::*;
#(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int POS_BITS   = 7,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  cell_op_t              cmd,
    input  logic [POS_BITS-1:0]   pos,
    input  logic [KEY_BITS-1:0]   ins_key,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic [KEY_BITS-1:0]   probe_begin,
    input  logic [KEY_BITS-1:0]   probe_end,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output cell_flags_t           flags
);

    localparam logic [POS_BITS-1:0] IDX = POS_BITS'(INDEX);

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        unique case (cmd)
            CELL_PULL:
            begin
                if (IDX >= pos)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            CELL_PUSH:
            begin
                if (IDX == pos)
                begin
                    key_next   = ins_key;
                    value_next = ins_value;
                end
                else if (IDX > pos)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key            = key_reg;
    assign value          = value_reg;
    assign flags.lt_begin = key_reg <  probe_begin;
    assign flags.le_begin = key_reg <= probe_begin;
    assign flags.lt_end   = key_reg <  probe_end;
    assign flags.eq_end   = key_reg == probe_end;

endmodule

>>> design/interval_range_table.sv
// Interval range table top level: item control, table scan and result register.
//
// Keeps a sorted table of up to CAPACITY boundaries, each opening a run of one
// value; keys below the first boundary read default_value. Input transfers use
// in_valid/in_ready, results use out_valid/out_ready, one result per item.
// op 0 assigns new_value to [key_begin, key_end); op 1 looks up key_begin.
// Write default_value through cfg_write_en/cfg_write_data only while idle; the
// block itself does not enforce this.
// Items are handled one at a time. After the input transfer an item passes the
// scan state; lookups, empty or rejected assigns then go to the result stage,
// while an accepted assign first runs the delete loop in the cell chain (one
// boundary deleted per cycle), then the end and begin insert states.
// A finished result sits in the output register; the next item is accepted
// meanwhile and only waits at its own result stage while out_ready is low.
// Reset clears the boundary count (empty table) and default_value to zero;
// cell contents are not cleared and are never read beyond the count.
module interval_range_table
    import irt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [VALUE_BITS-1:0]         cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [KEY_BITS-1:0]           key_begin,
    input  logic [KEY_BITS-1:0]           key_end,
    input  logic [VALUE_BITS-1:0]         new_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VALUE_BITS-1:0]         value_out,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic                          overflow,
    output logic                          empty_interval
);

    localparam int CW = $clog2(CAPACITY + 1);  // count / position width
    localparam int NW = CW + 2;                // room for count plus two inserts
    localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEL,
        S_INS_END,
        S_INS_BEGIN,
        S_LOOK
    } state_t;

    state_t state_reg, state_next;

    // item registers
    logic                  op_reg,  op_next;
    logic [KEY_BITS-1:0]   kb_reg,  kb_next;
    logic [KEY_BITS-1:0]   ke_reg,  ke_next;
    logic [VALUE_BITS-1:0] nv_reg,  nv_next;

    // table control
    logic [CW-1:0]         count_reg,  count_next;
    logic [CW-1:0]         pos_reg,    pos_next;
    logic [CW-1:0]         del_reg,    del_next;
    logic                  ins_b_reg,  ins_b_next;
    logic                  ins_e_reg,  ins_e_next;
    logic [VALUE_BITS-1:0] at_end_reg, at_end_next;
    logic                  ovf_reg,    ovf_next;
    logic                  emp_reg,    emp_next;
    logic [VALUE_BITS-1:0] default_value_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] value_out_reg, value_out_next;
    logic [CW-1:0]         count_out_reg, count_out_next;
    logic                  ovf_out_reg,   ovf_out_next;
    logic                  emp_out_reg,   emp_out_next;

    // cell chain
    cell_op_t              cmd;
    logic [KEY_BITS-1:0]   ins_key;
    logic [VALUE_BITS-1:0] ins_value;
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    cell_flags_t           cell_flags [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            // chain ends tie to the cell itself; those inputs are never selected
            // for live data
            localparam int L = (g == 0) ? 0 : g - 1;
            localparam int R = (g == CAPACITY - 1) ? g : g + 1;
            irt_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .POS_BITS   (CW),
                .INDEX      (g)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .pos         (pos_reg),
                .ins_key     (ins_key),
                .ins_value   (ins_value),
                .left_key    (cell_key[L]),
                .left_value  (cell_value[L]),
                .right_key   (cell_key[R]),
                .right_value (cell_value[R]),
                .probe_begin (kb_reg),
                .probe_end   (ke_reg),
                .key         (cell_key[g]),
                .value       (cell_value[g]),
                .flags       (cell_flags[g])
            );
        end
    endgenerate

    // Scan: flags form thermometer codes over the sorted, valid cells, so the
    // last set position of each picks the neighbor boundary.
    logic [CAPACITY-1:0]   lt_b, le_b, lt_e, eq_e;
    logic [CAPACITY-1:0]   lt_b_edge, le_b_edge, lt_e_edge;
    logic [CW-1:0]         ib, ie;
    logic [VALUE_BITS-1:0] before_sel, le_sel, lt_e_sel, hit_sel;
    logic                  end_hit;
    logic [VALUE_BITS-1:0] before_val, at_end_val, lookup_val;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_b[i] = cell_flags[i].lt_begin & (CW'(i) < count_reg);
            le_b[i] = cell_flags[i].le_begin & (CW'(i) < count_reg);
            lt_e[i] = cell_flags[i].lt_end   & (CW'(i) < count_reg);
            eq_e[i] = cell_flags[i].eq_end   & (CW'(i) < count_reg);
        end
        lt_b_edge = lt_b & ~(lt_b >> 1);
        le_b_edge = le_b & ~(le_b >> 1);
        lt_e_edge = lt_e & ~(lt_e >> 1);
        ib         = '0;
        ie         = '0;
        before_sel = '0;
        le_sel     = '0;
        lt_e_sel   = '0;
        hit_sel    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ib         = ib | (lt_b_edge[i] ? CW'(i + 1) : '0);
            ie         = ie | (lt_e_edge[i] ? CW'(i + 1) : '0);
            before_sel = before_sel | ({VALUE_BITS{lt_b_edge[i]}} & cell_value[i]);
            le_sel     = le_sel     | ({VALUE_BITS{le_b_edge[i]}} & cell_value[i]);
            lt_e_sel   = lt_e_sel   | ({VALUE_BITS{lt_e_edge[i]}} & cell_value[i]);
            hit_sel    = hit_sel    | ({VALUE_BITS{eq_e[i]}}      & cell_value[i]);
        end
        end_hit    = |eq_e;
        before_val = (|lt_b) ? before_sel : default_value_reg;
        lookup_val = (|le_b) ? le_sel : default_value_reg;
        at_end_val = end_hit ? hit_sel : ((|lt_e) ? lt_e_sel : default_value_reg);
    end

    logic          need_b, need_e;
    logic [CW-1:0] ie_end;
    logic [NW-1:0] need;

    assign need_b = nv_reg != before_val;
    assign need_e = nv_reg != at_end_val;
    assign ie_end = ie + CW'(end_hit);
    assign need   = NW'(ib) + NW'(need_b) + NW'(need_e) + NW'(count_reg - ie_end);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        kb_next        = kb_reg;
        ke_next        = ke_reg;
        nv_next        = nv_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        del_next       = del_reg;
        ins_b_next     = ins_b_reg;
        ins_e_next     = ins_e_reg;
        at_end_next    = at_end_reg;
        ovf_next       = ovf_reg;
        emp_next       = emp_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        value_out_next = value_out_reg;
        count_out_next = count_out_reg;
        ovf_out_next   = ovf_out_reg;
        emp_out_next   = emp_out_reg;
        cmd            = CELL_HOLD;
        ins_key        = ke_reg;
        ins_value      = at_end_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    kb_next    = key_begin;
                    ke_next    = key_end;
                    nv_next    = new_value;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ovf_next = 1'b0;
                emp_next = 1'b0;
                if (op_reg)
                    state_next = S_LOOK;
                else if (kb_reg >= ke_reg)
                begin
                    emp_next   = 1'b1;
                    state_next = S_LOOK;
                end
                else if (need > CAP_N)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_LOOK;
                end
                else
                begin
                    pos_next    = ib;
                    del_next    = ie_end - ib;
                    ins_b_next  = need_b;
                    ins_e_next  = need_e;
                    at_end_next = at_end_val;
                    state_next  = S_DEL;
                end
            end
            S_DEL:
            begin
                if (del_reg == '0)
                    state_next = S_INS_END;
                else
                begin
                    cmd        = CELL_PULL;
                    del_next   = del_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            S_INS_END:
            begin
                if (ins_e_reg)
                begin
                    cmd        = CELL_PUSH;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_INS_BEGIN;
            end
            S_INS_BEGIN:
            begin
                ins_key   = kb_reg;
                ins_value = nv_reg;
                if (ins_b_reg)
                begin
                    cmd        = CELL_PUSH;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = lookup_val;
                    count_out_next = count_reg;
                    ovf_out_next   = ovf_reg;
                    emp_out_next   = emp_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            default_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                default_value_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        kb_reg        <= kb_next;
        ke_reg        <= ke_next;
        nv_reg        <= nv_next;
        pos_reg       <= pos_next;
        del_reg       <= del_next;
        ins_b_reg     <= ins_b_next;
        ins_e_reg     <= ins_e_next;
        at_end_reg    <= at_end_next;
        ovf_reg       <= ovf_next;
        emp_reg       <= emp_next;
        value_out_reg <= value_out_next;
        count_out_reg <= count_out_next;
        ovf_out_reg   <= ovf_out_next;
        emp_out_reg   <= emp_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign value_out      = value_out_reg;
    assign entry_count    = count_out_reg;
    assign overflow       = ovf_out_reg;
    assign empty_interval = emp_out_reg;

    // table never holds more than its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("boundary count above capacity");

    // each delete step removes exactly one boundary
    a_del_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL && del_reg != '0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete step count mismatch");

    // a result is never both rejected and empty
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(ovf_out_reg && emp_out_reg))
        else $error("overflow and empty both flagged");

endmodule
